// ===== hw/rtl/ita_pkg.sv =====
// Package: shared types, constants and helpers of the integer-to-ASCII formatter.
`default_nettype none
package ita_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned DEC_DIGITS = 10;
  localparam int unsigned HEX_MAX    = 8;
  localparam int unsigned BCD_W      = DEC_DIGITS * NIB_W;
  localparam int unsigned STEP_W     = 6;

  // Command codes
  localparam logic CMD_DEC = 1'b0;
  localparam logic CMD_HEX = 1'b1;

  // Character codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Status of the double-dabble unit
  typedef struct packed {
    logic             busy;
    logic [BCD_W-1:0] bcd;
  } dab_stat_t;

  // One nibble as '0'-'9' / 'A'-'F'
  function automatic logic [7:0] nib_to_ascii(input logic [NIB_W-1:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    if (nib < 4'd10) begin
      nib_to_ascii = CHAR_ZERO + wide;
    end else begin
      nib_to_ascii = CHAR_A + wide - 8'd10;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ita_if.sv =====
// Interfaces: input channel and character channel of the formatter.
`default_nettype none
interface ita_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] value;
  logic [3:0]  hex_digits;

  modport source (output valid, output command, output value, output hex_digits,
                  input ready);
  modport sink   (input valid, input command, input value, input hex_digits,
                  output ready);
endinterface

interface ita_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/integer_to_ascii_formatter.sv =====
// Top level: sequencer, digit register and output register of the formatter.
`default_nettype none
// Formats one 32-bit word per input transfer as ASCII characters, most significant
// first, with last set on the final character. command 0 prints the word as a
// signed decimal (leading '-', no leading zeros, "0" for zero); command 1 prints
// the low hex_digits nibbles (saturated at 8) as 0-9/A-F, and nothing at all for
// zero digits. One item at a time: in_ch.ready is high only while the sequencer
// is idle. A decimal item runs the conversion (32 double-dabble steps plus the
// handoff of the result), then drops leading zeros in ST_SKIP, loads a '-' in
// ST_SIGN when negative and the digits in ST_EMIT. Dropped zeros and digits
// always add up to ten. A hex item with n digits drops 8 - n high nibbles in
// ST_SKIP and then emits n digits; with zero digits it emits nothing. A stalled
// output register holds the sequencer in ST_SIGN or ST_EMIT. The next item may
// be accepted while the final character still waits in the output register.
module integer_to_ascii_formatter
  import ita_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  ita_in_if.sink     in_ch,
  ita_out_if.source  out_ch
);

  state_t           state_r, state_nxt;
  logic [BCD_W-1:0] dig_r, dig_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [3:0]       lim_r, lim_nxt;
  logic             hex_r, hex_nxt;
  logic             neg_r, neg_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic             out_last_r, out_last_nxt;

  logic              in_xfer;
  logic              slot_free;
  logic              dab_start;
  logic [WORD_W-1:0] dab_mag;
  dab_stat_t         dab_stat;
  logic [NIB_W-1:0]  top_nib;
  logic [3:0]        hex_n;
  logic              skip;

  ita_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dab_start),
    .mag   (dab_mag),
    .stat  (dab_stat)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign top_nib     = dig_r[BCD_W-1 -: NIB_W];
  assign hex_n       = (in_ch.hex_digits > 4'(HEX_MAX)) ? 4'(HEX_MAX) : in_ch.hex_digits;
  assign dab_start   = in_xfer && (in_ch.command == CMD_DEC);
  assign dab_mag     = in_ch.value[WORD_W-1] ? (WORD_W'(0) - in_ch.value) : in_ch.value;
  // Drop leading zeros in decimal, unwanted high nibbles in hex
  assign skip        = (cnt_r > lim_r) && (hex_r || (top_nib == '0));

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    dig_nxt       = dig_r;
    cnt_nxt       = cnt_r;
    lim_nxt       = lim_r;
    hex_nxt       = hex_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_ch.command == CMD_HEX) begin
            dig_nxt = {in_ch.value, {(BCD_W-WORD_W){1'b0}}};
            cnt_nxt = 4'(HEX_MAX);
            lim_nxt = hex_n;
            hex_nxt = 1'b1;
            neg_nxt = 1'b0;
            if (hex_n != '0) begin
              state_nxt = ST_SKIP;
            end
          end else begin
            cnt_nxt   = 4'(DEC_DIGITS);
            lim_nxt   = 4'd1;
            hex_nxt   = 1'b0;
            neg_nxt   = in_ch.value[WORD_W-1];
            state_nxt = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        if (!dab_stat.busy) begin
          dig_nxt   = dab_stat.bcd;
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (skip) begin
          dig_nxt = {dig_r[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = nib_to_ascii(top_nib);
          out_last_nxt  = (cnt_r == 4'd1);
          dig_nxt       = {dig_r[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
          cnt_nxt       = cnt_r - 1'b1;
          if (cnt_r == 4'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dig_r      <= dig_nxt;
    cnt_r      <= cnt_nxt;
    lim_r      <= lim_nxt;
    hex_r      <= hex_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;

`ifndef ASSERT_OFF
  // Digit emission never starts from an empty count
  a_emit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (cnt_r != '0))
    else $error("emit with zero digit count");

  // Loading the final character returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && slot_free && cnt_r == 4'd1) |=> (in_ch.ready && out_ch.last))
    else $error("final character did not end the item");

  // A decimal transfer starts the conversion unit
  a_dec_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.command == CMD_DEC) |=> (state_r == ST_CONV && dab_stat.busy))
    else $error("decimal transfer did not start conversion");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/ita_dabble.sv =====
// Iterative binary-to-BCD unit: one shift-add-3 step per cycle, 32 steps per word.
`default_nettype none
module ita_dabble
  import ita_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] mag,
  output      dab_stat_t         stat
);

  logic [WORD_W-1:0] shift_r, shift_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [BCD_W-1:0]  bcd_adj;

  // Add 3 to every digit of 5 or more, digits are independent
  always_comb begin
    for (int d = 0; d < DEC_DIGITS; d++) begin
      if (bcd_r[d*NIB_W +: NIB_W] >= 4'd5) begin
        bcd_adj[d*NIB_W +: NIB_W] = bcd_r[d*NIB_W +: NIB_W] + 4'd3;
      end else begin
        bcd_adj[d*NIB_W +: NIB_W] = bcd_r[d*NIB_W +: NIB_W];
      end
    end
  end

  // Load on start, then shift one binary bit into the BCD word per cycle
  always_comb begin
    shift_nxt = shift_r;
    bcd_nxt   = bcd_r;
    step_nxt  = step_r;
    if (start) begin
      shift_nxt = mag;
      bcd_nxt   = '0;
      step_nxt  = STEP_W'(WORD_W);
    end else if (step_r != '0) begin
      {bcd_nxt, shift_nxt} = {bcd_adj[BCD_W-2:0], shift_r, 1'b0};
      step_nxt             = step_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
    shift_r <= shift_nxt;
    bcd_r   <= bcd_nxt;
  end

  assign stat.busy = (step_r != '0);
  assign stat.bcd  = bcd_r;

endmodule
`default_nettype wire

// ===== bench/integer_to_ascii_formatter_tb.sv =====
// Testbench for integer_to_ascii_formatter: directed table, random items, character checks.
`timescale 1ns / 100ps
module integer_to_ascii_formatter_tb;
  import ita_pkg::*;

  localparam int ITEMS_PER_PHASE = 87;
  localparam int DRAIN_CYCLES    = 64;

  // One expected character of a formatted run
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_exp_t;

  // One row of the directed table; text is used only when typed is set
  typedef struct {
    logic        cmd;
    logic [31:0] word;
    logic [3:0]  nd;
    bit          typed;
    string       text;
  } fmt_case_t;

  logic clk;
  logic rst_n;

  ita_in_if  in_bus ();
  ita_out_if out_bus ();

  integer_to_ascii_formatter u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  char_exp_t pending_chars[$];
  fmt_case_t dir_cases[$];
  int        err_count;
  int        src_idle_pct;
  int        snk_stall_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("integer_to_ascii_formatter regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Expected characters for one item, queued in print order
  function automatic void predict_chars(input logic cmd, input logic [31:0] word,
                                        input logic [3:0] nd);
    logic [31:0] mag;
    logic [7:0]  rev[10];
    logic [7:0]  run[$];
    logic [3:0]  nib;
    int          nrev;
    int          n;
    if (cmd == CMD_HEX) begin
      n = (nd > HEX_MAX) ? HEX_MAX : nd;
      for (int i = n - 1; i >= 0; i--) begin
        nib = word[i*4 +: 4];
        run.push_back((nib < 4'd10) ? CHAR_ZERO + nib : CHAR_A + nib - 8'd10);
      end
    end else begin
      // magnitude as unsigned, so the most negative word needs no special path
      mag  = word[31] ? -word : word;
      nrev = 0;
      do begin
        rev[nrev] = CHAR_ZERO + 8'(mag % 10);
        mag       = mag / 10;
        nrev++;
      end while (mag != 0);
      if (word[31]) run.push_back(CHAR_MINUS);
      for (int i = nrev - 1; i >= 0; i--) run.push_back(rev[i]);
    end
    for (int k = 0; k < run.size(); k++) pending_chars.push_back('{run[k], k == run.size() - 1});
  endfunction

  function automatic void push_text(input string s);
    for (int k = 0; k < s.len(); k++) pending_chars.push_back('{s[k], k == s.len() - 1});
  endfunction

  // Drive one item from a falling edge; returns at the next falling edge after the transfer
  task automatic send_item(input logic cmd, input logic [31:0] word, input logic [3:0] nd,
                           input bit typed, input string text);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid      = 1'b1;
    in_bus.command    = cmd;
    in_bus.value      = word;
    in_bus.hex_digits = nd;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (typed) push_text(text);
    else predict_chars(cmd, word, nd);
    @(negedge clk);
  endtask

  // Result side back-pressure
  always @(negedge clk) begin
    out_bus.ready = ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    char_exp_t exp_c;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character %h last %b",
                                  out_bus.character, out_bus.last));
      end else begin
        exp_c = pending_chars.pop_front();
        if (out_bus.character !== exp_c.ch)
          report_mismatch($sformatf("character %h, expected %h",
                                    out_bus.character, exp_c.ch));
        if (out_bus.last !== exp_c.last)
          report_mismatch($sformatf("last %b on character %h, expected %b",
                                    out_bus.last, exp_c.ch, exp_c.last));
      end
    end
  end

  // Stimulus
  initial begin
    logic [31:0] w;
    logic [3:0]  nd;
    int          k;
    err_count         = 0;
    src_idle_pct      = 0;
    snk_stall_pct     = 0;
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.command    = CMD_DEC;
    in_bus.value      = '0;
    in_bus.hex_digits = '0;

    // extremes, every command, zero digits, saturation, most negative word
    dir_cases.push_back('{CMD_DEC, 32'h0000_0000, 4'd0,  1'b1, "0"});
    dir_cases.push_back('{CMD_DEC, 32'h0000_0001, 4'd0,  1'b1, "1"});
    dir_cases.push_back('{CMD_DEC, 32'h0000_0009, 4'd0,  1'b1, "9"});
    dir_cases.push_back('{CMD_DEC, 32'h0000_000A, 4'd0,  1'b1, "10"});
    dir_cases.push_back('{CMD_DEC, 32'h7FFF_FFFF, 4'd0,  1'b1, "2147483647"});
    dir_cases.push_back('{CMD_DEC, 32'h8000_0000, 4'd0,  1'b1, "-2147483648"});
    dir_cases.push_back('{CMD_DEC, 32'h8000_0001, 4'd0,  1'b1, "-2147483647"});
    dir_cases.push_back('{CMD_DEC, 32'hFFFF_FFFF, 4'd0,  1'b1, "-1"});
    dir_cases.push_back('{CMD_DEC, 32'hFFFF_FFF6, 4'd0,  1'b1, "-10"});
    dir_cases.push_back('{CMD_DEC, 32'd1000000000, 4'd0, 1'b1, "1000000000"});
    dir_cases.push_back('{CMD_DEC, 32'd999999999, 4'd0,  1'b0, ""});
    dir_cases.push_back('{CMD_DEC, 32'h1234_5678, 4'd0,  1'b0, ""});
    dir_cases.push_back('{CMD_DEC, 32'h0000_0000, 4'd15, 1'b1, "0"});
    dir_cases.push_back('{CMD_HEX, 32'hFFFF_FFFF, 4'd0,  1'b1, ""});
    dir_cases.push_back('{CMD_HEX, 32'h0000_0000, 4'd0,  1'b1, ""});
    dir_cases.push_back('{CMD_HEX, 32'h0000_000F, 4'd1,  1'b1, "F"});
    dir_cases.push_back('{CMD_HEX, 32'h0000_000A, 4'd1,  1'b1, "A"});
    dir_cases.push_back('{CMD_HEX, 32'h0000_0009, 4'd1,  1'b1, "9"});
    dir_cases.push_back('{CMD_HEX, 32'hDEAD_BEEF, 4'd8,  1'b1, "DEADBEEF"});
    dir_cases.push_back('{CMD_HEX, 32'h0000_0000, 4'd8,  1'b1, "00000000"});
    dir_cases.push_back('{CMD_HEX, 32'hFFFF_FFFF, 4'd8,  1'b1, "FFFFFFFF"});
    dir_cases.push_back('{CMD_HEX, 32'h0123_ABCD, 4'd15, 1'b1, "0123ABCD"});
    dir_cases.push_back('{CMD_HEX, 32'h89AB_CDEF, 4'd9,  1'b1, "89ABCDEF"});
    dir_cases.push_back('{CMD_HEX, 32'h1234_5678, 4'd4,  1'b1, "5678"});
    dir_cases.push_back('{CMD_HEX, 32'hCAFE_1234, 4'd3,  1'b0, ""});

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_cases[i])
      send_item(dir_cases[i].cmd, dir_cases[i].word, dir_cases[i].nd,
                dir_cases[i].typed, dir_cases[i].text);

    // random items over four idle/stall phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 61; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 61; end
        default: begin src_idle_pct = 29; snk_stall_pct = 29; end
      endcase
      repeat (ITEMS_PER_PHASE) begin
        w = $urandom;
        if ($urandom_range(0, 1) == 0) begin
          // decimal: spread magnitudes over all lengths, both signs
          k = $urandom_range(0, 32);
          if (k < 32) w = w & ((32'd1 << k) - 32'd1);
          if ($urandom_range(0, 1) == 1) w = -w;
          if ($urandom_range(0, 19) == 0) w = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          nd = 4'($urandom_range(0, 15));
          send_item(CMD_DEC, w, nd, 1'b0, "");
        end else begin
          nd = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(1, 8));
          send_item(CMD_HEX, w, nd, 1'b0, "");
        end
      end
    end
    in_bus.valid = 1'b0;

    // drain, then let any stray character show up
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("integer_to_ascii_formatter regression: pass");
    end else begin
      $display("integer_to_ascii_formatter regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ita_pkg.sv
hw/rtl/ita_if.sv
hw/rtl/ita_dabble.sv
hw/rtl/integer_to_ascii_formatter.sv
bench/integer_to_ascii_formatter_tb.sv
